FILE: rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants for the binary trie longest prefix match block.
// ----------------------------------------------------------------------------
package lpm_pkg;

	localparam int ADDR_BITS = 32;
	localparam int LEN_W     = 6;
	localparam int STATUS_W  = 3;
	localparam int PORT_W    = 4;

	typedef enum logic [0:0] {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT       = 3'd0,
		ST_DEFAULT   = 3'd1,
		ST_NOROUTE   = 3'd2,
		ST_INSERTED  = 3'd3,
		ST_DUPLICATE = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_WAIT,
		S_CHECK,
		S_ALLOC,
		S_MARK,
		S_OUT
	} state_t;

endpackage

FILE: rtl/lpm_if.sv
// ----------------------------------------------------------------------------
// lpm_req_if / lpm_rsp_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface lpm_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  opcode;
	logic [31:0] dest_address;
	logic [5:0]  prefix_len;
	logic [31:0] next_hop;
	logic [3:0]  port_index;

	modport source (output valid, opcode, dest_address, prefix_len, next_hop, port_index,
		input ready);
	modport sink (input valid, opcode, dest_address, prefix_len, next_hop, port_index,
		output ready);
endinterface

interface lpm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] route_gateway;
	logic [3:0]  route_port;

	modport source (output valid, status, route_gateway, route_port, input ready);
	modport sink (input valid, status, route_gateway, route_port, output ready);
endinterface

FILE: rtl/lpm_ram.sv
// ----------------------------------------------------------------------------
// lpm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// registered read, returns the old word on a write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/ipv4_longest_prefix_match_trie_top.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_trie_top
// IPv4 route table as a binary trie with insert and longest-prefix lookup.
// ----------------------------------------------------------------------------
// One word is taken at a time; ready is high only while idle. The trie walk
// reads one node per level from the node memory; each level passes through
// an address state (S_WALK) and a registered-read state (S_WAIT). An insert
// adds a marking state for an existing node or a pool check state, plus an
// allocation state for each newly allocated node. A stalled result holds the
// block in its output state. Memory is not cleared: every node is written
// when allocated, and the root and default route live in flip-flops.
module ipv4_longest_prefix_match_trie_top #(
	parameter int NODE_COUNT = 1024,
	parameter int PORT_COUNT = 16
) (
	input logic     clk,
	input logic     arst_n,
	lpm_req_if.sink   req,
	lpm_rsp_if.source rsp
);
	localparam int NW = $clog2(NODE_COUNT);
	localparam int RW = 2*NW + 1 + 32 + lpm_pkg::PORT_W;

	lpm_pkg::state_t state_q, state_d;

	logic              op_q;
	logic [31:0]       addr_q, gw_q;
	logic [5:0]        len_q, lvl_q;
	logic [3:0]        port_q;
	logic [NW-1:0]     cur_q, found_q;
	logic [NW:0]       free_q;
	logic [NW-1:0]     root_l_q, root_r_q;
	logic              dflt_v_q;
	logic [31:0]       dflt_gw_q;
	logic [3:0]        dflt_port_q;
	logic [2:0]        st_q;
	logic [31:0]       ogw_q;
	logic [3:0]        oport_q;

	// node memory: {left, right, entry, gateway, port}
	logic          we;
	logic [NW-1:0] maddr;
	logic [RW-1:0] wdata, rdata;
	lpm_ram #(.WIDTH(RW), .DEPTH(NODE_COUNT)) u_ram (
		.clk(clk), .we(we), .addr(maddr), .wdata(wdata), .rdata(rdata));

	logic [NW-1:0] r_left, r_right;
	logic          r_entry;
	logic [31:0]   r_gw;
	logic [3:0]    r_port;
	assign {r_left, r_right, r_entry, r_gw, r_port} = rdata;

	logic          bit_c;
	logic          bit_n;
	logic [NW-1:0] child;
	logic [NW-1:0] nxt_free;
	logic          at_root;
	logic [NW:0]   need;
	logic          full;
	logic [5:0]    len_c;
	logic [3:0]    port_c;
	assign at_root  = (cur_q == '0);
	assign bit_c    = addr_q[5'(31 - lvl_q[4:0])];
	assign bit_n    = addr_q[5'(30 - lvl_q[4:0])];
	assign child    = at_root ? (bit_c ? root_r_q : root_l_q) : (bit_c ? r_right : r_left);
	assign nxt_free = free_q[NW-1:0] + (NW)'(1);
	assign need     = (NW+1)'(len_q - lvl_q);
	assign full     = (free_q > NODE_COUNT[NW:0]) || (need > (NODE_COUNT[NW:0] - free_q));
	assign len_c    = (req.prefix_len > 6'd32) ? 6'd32 : req.prefix_len;
	assign port_c   = (32'(req.port_index) >= PORT_COUNT) ? 4'(PORT_COUNT-1) : req.port_index;

	logic walk_done;
	logic descend;
	logic hit_c;
	logic alloc_last;
	// walk ends when depth reached (insert) or address exhausted (lookup)
	assign walk_done  = (op_q == lpm_pkg::OP_INSERT) ? (lvl_q == len_q) : (lvl_q == 6'd32);
	assign descend    = !walk_done && (child != '0);
	assign hit_c      = !at_root && r_entry;
	assign alloc_last = (lvl_q + 6'd1 == len_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpm_pkg::S_IDLE:   if (req.valid) state_d = lpm_pkg::S_WALK;
			lpm_pkg::S_WALK: begin
				if (op_q == lpm_pkg::OP_INSERT) begin
					if (len_q == '0) state_d = lpm_pkg::S_OUT;
					else if (walk_done) state_d = r_entry ? lpm_pkg::S_OUT : lpm_pkg::S_MARK;
					else if (child == '0) state_d = lpm_pkg::S_CHECK;
					else state_d = lpm_pkg::S_WAIT;
				end else if (descend) begin
					state_d = lpm_pkg::S_WAIT;
				end else begin
					state_d = lpm_pkg::S_OUT;
				end
			end
			lpm_pkg::S_WAIT:   state_d = lpm_pkg::S_WALK;
			lpm_pkg::S_CHECK: begin
				if (full) state_d = lpm_pkg::S_OUT;
				else state_d = lpm_pkg::S_ALLOC;
			end
			lpm_pkg::S_ALLOC:  if (alloc_last) state_d = lpm_pkg::S_OUT;
			lpm_pkg::S_MARK:   state_d = lpm_pkg::S_OUT;
			lpm_pkg::S_OUT:    if (rsp.ready) state_d = lpm_pkg::S_IDLE;
			default:           state_d = lpm_pkg::S_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		we    = 1'b0;
		maddr = cur_q;
		wdata = rdata;
		case (state_q)
			lpm_pkg::S_WALK: if (descend) maddr = child;
			lpm_pkg::S_CHECK: begin
				// link the first new node below the last existing one
				we    = !full && !at_root;
				wdata = {bit_c ? r_left : free_q[NW-1:0], bit_c ? free_q[NW-1:0] : r_right,
					r_entry, r_gw, r_port};
			end
			lpm_pkg::S_ALLOC: begin
				we    = 1'b1;
				maddr = free_q[NW-1:0];
				// new nodes form a chain; the last one carries the route
				if (alloc_last)
					wdata = {{(2*NW){1'b0}}, 1'b1, gw_q, port_q};
				else
					wdata = {bit_n ? {NW{1'b0}} : nxt_free, bit_n ? nxt_free : {NW{1'b0}},
						1'b0, 32'd0, 4'd0};
			end
			lpm_pkg::S_MARK: begin
				we    = 1'b1;
				wdata = {r_left, r_right, 1'b1, gw_q, port_q};
			end
			default: ;
		endcase
	end
	assign req.ready         = (state_q == lpm_pkg::S_IDLE);
	assign rsp.valid         = (state_q == lpm_pkg::S_OUT);
	assign rsp.status        = st_q;
	assign rsp.route_gateway = ogw_q;
	assign rsp.route_port    = oport_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lpm_pkg::S_IDLE;
			root_l_q <= '0;
			root_r_q <= '0;
			free_q   <= (NW+1)'(1);
			dflt_v_q <= 1'b0;
			dflt_gw_q   <= '0;
			dflt_port_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lpm_pkg::S_WALK && op_q == lpm_pkg::OP_INSERT && len_q == '0) begin
				dflt_v_q    <= 1'b1;
				dflt_gw_q   <= gw_q;
				dflt_port_q <= port_q;
			end
			if (state_q == lpm_pkg::S_CHECK && !full && at_root) begin
				if (bit_c) root_r_q <= free_q[NW-1:0];
				else root_l_q <= free_q[NW-1:0];
			end
			if (state_q == lpm_pkg::S_ALLOC) begin
				free_q <= free_q + (NW+1)'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			lpm_pkg::S_IDLE: begin
				op_q    <= req.opcode;
				addr_q  <= req.dest_address;
				len_q   <= len_c;
				gw_q    <= req.next_hop;
				port_q  <= port_c;
				cur_q   <= '0;
				lvl_q   <= '0;
				found_q <= '0;
			end
			lpm_pkg::S_WALK: begin
				if (descend) begin
					cur_q <= child;
					lvl_q <= lvl_q + 6'd1;
				end
				if (op_q == lpm_pkg::OP_INSERT) begin
					// default route, or a path ending on an existing entry
					if (len_q == '0 || (walk_done && r_entry)) begin
						st_q    <= (len_q == '0) ? lpm_pkg::ST_INSERTED : lpm_pkg::ST_DUPLICATE;
						ogw_q   <= '0;
						oport_q <= '0;
					end
				end else begin
					// remember the deepest entry passed so far
					if (hit_c) begin
						found_q <= cur_q;
						ogw_q   <= r_gw;
						oport_q <= r_port;
					end
					if (!descend) begin
						if (hit_c || found_q != '0) begin
							st_q <= lpm_pkg::ST_HIT;
						end else begin
							st_q    <= dflt_v_q ? lpm_pkg::ST_DEFAULT : lpm_pkg::ST_NOROUTE;
							ogw_q   <= dflt_v_q ? dflt_gw_q : '0;
							oport_q <= dflt_v_q ? dflt_port_q : '0;
						end
					end
				end
			end
			lpm_pkg::S_CHECK: begin
				st_q    <= full ? lpm_pkg::ST_FULL : lpm_pkg::ST_INSERTED;
				ogw_q   <= '0;
				oport_q <= '0;
			end
			lpm_pkg::S_ALLOC: begin
				lvl_q <= lvl_q + 6'd1;
			end
			lpm_pkg::S_MARK: begin
				st_q <= lpm_pkg::ST_INSERTED;
				ogw_q <= '0;
				oport_q <= '0;
			end
			default: ;
		endcase
	end
endmodule

FILE: tb/sv/tb_ipv4_longest_prefix_match_trie_top.sv
// ----------------------------------------------------------------------------
// tb_ipv4_longest_prefix_match_trie_top
// Drives route inserts and address lookups into the trie route table. Each
// result word is checked against an in-bench copy of the trie, the default
// route and the node allocator, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_ipv4_longest_prefix_match_trie_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES      = 1024;
	localparam int PORTS      = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_LEN   = 400;
	localparam int RAND_ITEMS = 1730;

	typedef struct {
		lpm_pkg::op_t op;
		logic [31:0]  addr;
		logic [5:0]   len;
		logic [31:0]  gw;
		logic [3:0]   port;
		bit           drain;
	} route_op_t;

	typedef struct {
		lpm_pkg::status_t status;
		logic [31:0]      gw;
		logic [3:0]       port;
	} route_res_t;

	logic clk;
	logic arst_n;

	lpm_req_if req ();
	lpm_rsp_if rsp ();

	ipv4_longest_prefix_match_trie_top #(.NODE_COUNT(NODES), .PORT_COUNT(PORTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// trie mirror
	logic [9:0]  trie_left  [NODES];
	logic [9:0]  trie_right [NODES];
	bit          trie_entry [NODES];
	logic [31:0] trie_gw    [NODES];
	logic [3:0]  trie_port  [NODES];
	logic [9:0]  top_left, top_right;
	int unsigned free_node;
	bit          dflt_valid;
	logic [31:0] dflt_gw;
	logic [3:0]  dflt_port;

	route_op_t   pending_ops [$];
	route_res_t  route_results [$];
	route_op_t   on_bus;
	logic [31:0] bases [8];
	int          mismatches;
	int          cycle_cnt;
	int          quiet_cnt;
	bit          failed;

	function automatic void queue_op(route_op_t o);
		pending_ops = {pending_ops, o};
	endfunction

	function automatic void queue_result(route_res_t r);
		route_results = {route_results, r};
	endfunction

	function automatic logic [9:0] child_at(int unsigned cur, bit b);
		if (cur == 0)
			return b ? top_right : top_left;
		return b ? trie_right[cur] : trie_left[cur];
	endfunction

	function automatic void link_child(int unsigned cur, bit b, logic [9:0] node);
		if (cur == 0) begin
			if (b) top_right = node; else top_left = node;
		end else begin
			if (b) trie_right[cur] = node; else trie_left[cur] = node;
		end
	endfunction

	// apply one operation to the mirror and return its result word
	function automatic route_res_t route_apply(route_op_t o);
		route_res_t r;
		int unsigned cur, i, len, found, nxt;
		logic [3:0] p;
		r.status = lpm_pkg::ST_NOROUTE;
		r.gw = '0;
		r.port = '0;
		cur = 0;
		i = 0;
		found = 0;
		if (o.op == lpm_pkg::OP_INSERT) begin
			len = (o.len > 32) ? 32 : o.len;
			p = (o.port >= PORTS) ? 4'(PORTS - 1) : o.port;
			r.status = lpm_pkg::ST_INSERTED;
			if (len == 0) begin
				dflt_valid = 1;
				dflt_gw = o.gw;
				dflt_port = p;
				return r;
			end
			while (i < len) begin
				nxt = child_at(cur, o.addr[31-i]);
				if (nxt == 0) break;
				cur = nxt;
				i++;
			end
			if (i == len) begin
				if (trie_entry[cur]) begin
					r.status = lpm_pkg::ST_DUPLICATE;
					return r;
				end
			end else begin
				if (len - i > NODES - free_node) begin
					r.status = lpm_pkg::ST_FULL;
					return r;
				end
				while (i < len) begin
					nxt = free_node;
					free_node++;
					trie_left[nxt] = '0;
					trie_right[nxt] = '0;
					trie_entry[nxt] = 0;
					link_child(cur, o.addr[31-i], nxt[9:0]);
					cur = nxt;
					i++;
				end
			end
			trie_entry[cur] = 1;
			trie_gw[cur] = o.gw;
			trie_port[cur] = p;
			return r;
		end
		// longest prefix lookup
		for (i = 0; i <= 32; i++) begin
			if (cur != 0 && trie_entry[cur])
				found = cur;
			if (i == 32) break;
			nxt = child_at(cur, o.addr[31-i]);
			if (nxt == 0) break;
			cur = nxt;
		end
		if (found != 0) begin
			r.status = lpm_pkg::ST_HIT;
			r.gw = trie_gw[found];
			r.port = trie_port[found];
		end else if (dflt_valid) begin
			r.status = lpm_pkg::ST_DEFAULT;
			r.gw = dflt_gw;
			r.port = dflt_port;
		end
		return r;
	endfunction

	function automatic route_op_t mk_op(lpm_pkg::op_t op, logic [31:0] a, int l,
		logic [31:0] g, int p);
		route_op_t o;
		o.op = op;
		o.addr = a;
		o.len = l[5:0];
		o.gw = g;
		o.port = p[3:0];
		o.drain = 0;
		return o;
	endfunction

	function automatic logic [31:0] near_base();
		logic [31:0] m;
		m = $urandom_range(0, 3) == 0 ? $urandom() : ($urandom() >> $urandom_range(4, 31));
		return bases[$urandom_range(0, 7)] ^ m;
	endfunction

	// clock
	initial clk = 0;
	always #5 clk = ~clk;

	// random idling, with a stretch of no idling in the middle of the run
	function automatic bit idle_now();
		if (cycle_cnt > 30000 && cycle_cnt < 45000)
			return 0;
		return $urandom_range(0, 99) < 6;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= lpm_pkg::OP_LOOKUP;
			req.dest_address <= '0;
			req.prefix_len <= '0;
			req.next_hop <= '0;
			req.port_index <= '0;
		end else begin
			if (req.valid && req.ready)
				queue_result(route_apply(on_bus));
			if (!req.valid || req.ready) begin
				if (pending_ops.size() > 0 && !idle_now()
					&& !(pending_ops[0].drain && route_results.size() > 0)) begin
					on_bus = pending_ops.pop_front();
					req.valid <= 1'b1;
					req.opcode <= on_bus.op;
					req.dest_address <= on_bus.addr;
					req.prefix_len <= on_bus.len;
					req.next_hop <= on_bus.gw;
					req.port_index <= on_bus.port;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// result sink, with one long hold-off so the block backs up
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (cycle_cnt == 8000)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= !idle_now();
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		route_res_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (route_results.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d gw %h port %0d",
						rsp.status, rsp.route_gateway, rsp.route_port);
			end else begin
				e = route_results.pop_front();
				if (rsp.status !== e.status || rsp.route_gateway !== e.gw
					|| rsp.route_port !== e.port) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %0d/%h/%0d got %0d/%h/%0d",
							e.status, e.gw, e.port,
							rsp.status, rsp.route_gateway, rsp.route_port);
				end
			end
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		cycle_cnt++;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cnt = 0;
		else
			quiet_cnt++;
		if (quiet_cnt >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		route_op_t o;
		int k, r;
		cycle_cnt = 0;
		quiet_cnt = 0;
		mismatches = 0;
		failed = 0;
		top_left = '0;
		top_right = '0;
		free_node = 1;
		dflt_valid = 0;
		dflt_gw = '0;
		dflt_port = '0;
		for (k = 0; k < 8; k++)
			bases[k] = $urandom();

		// directed: empty table, default route, nesting, duplicates, clamping
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h0a010203, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h0a010203, 0, 32'h01020304, 7));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h0a010203, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h0a000000, 8, 32'h0a0000fe, 1));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h0a050607, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h0a000000, 8, 32'hdeadbeef, 2));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h0a010200, 24, 32'h0a0102fe, 3));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h0a0102ff, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h0a0103ff, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h0a010000, 16, 32'h0a01fffe, 4));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h0a0103ff, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'hffffffff, 32, 32'hffffffff, 15));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'hffffffff, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'hfffffffe, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h00000000, 63, 32'h00000000, 0));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h00000000, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h00000000, 33, 32'h12345678, 9));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h80000000, 1, 32'h80000001, 5));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'hc0000000, 0, 0, 0));
		queue_op(mk_op(lpm_pkg::OP_INSERT, 32'h55555555, 0, 32'hfffffffe, 15));
		queue_op(mk_op(lpm_pkg::OP_LOOKUP, 32'h40000000, 0, 0, 0));

		// random: inserts and lookups clustered around a few prefixes
		for (k = 0; k < RAND_ITEMS; k++) begin
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 99);
				o = mk_op(lpm_pkg::OP_INSERT, near_base(),
					r < 70 ? $urandom_range(1, 24) : r < 90 ? $urandom_range(25, 32) :
					r < 95 ? 0 : $urandom_range(33, 63),
					$urandom(), $urandom_range(0, 15));
			end else begin
				o = mk_op(lpm_pkg::OP_LOOKUP,
					$urandom_range(0, 4) == 0 ? $urandom() : near_base(),
					$urandom_range(0, 63), $urandom(), $urandom_range(0, 15));
			end
			o.drain = (k == 900);
			queue_op(o);
		end

		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		wait (pending_ops.size() == 0 && !req.valid);
		wait (route_results.size() == 0);
		repeat (200) @(posedge clk);
		if (!failed && mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lpm_pkg.sv
rtl/lpm_if.sv
rtl/lpm_ram.sv
rtl/ipv4_longest_prefix_match_trie_top.sv
tb/sv/tb_ipv4_longest_prefix_match_trie_top.sv
